FILE: hw/rtl/acbc_pkg.sv
package acbc_pkg;

  localparam int BLK_W = 128;
  localparam int TDATA_W = 136;

  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_KEY_SIZE = 3'd1;
  localparam logic [2:0] REG_KEY_WORD0 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD1 = 3'd3;
  localparam logic [2:0] REG_KEY_WORD2 = 3'd4;
  localparam logic [2:0] REG_KEY_WORD3 = 3'd5;
  localparam logic [2:0] REG_IV_HIGH = 3'd6;
  localparam logic [2:0] REG_IV_LOW = 3'd7;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  typedef struct packed {
    logic       capture;
    logic       kexp;
    logic [5:0] kidx;
    logic       load;
    logic       use_iv;
    logic       pad;
    logic       round;
    logic       final_round;
    logic [3:0] rk_idx;
    logic       finish;
  } acbc_cmd_t;

  typedef struct packed {
    logic [3:0] nr;
    logic       dir;
    logic       extra;
    logic       out_free;
  } acbc_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a, b, d, e;
    a = w[31:24]; b = w[23:16]; d = w[15:8]; e = w[7:0];
    mix_col = {xtime(a) ^ xtime(b) ^ b ^ d ^ e,
               a ^ xtime(b) ^ xtime(d) ^ d ^ e,
               a ^ b ^ xtime(d) ^ xtime(e) ^ e,
               xtime(a) ^ a ^ b ^ d ^ xtime(e)};
  endfunction

  // inverse mix as a pre-multiply by {04,05} followed by the forward mix
  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a, b, d, e, u, v;
    a = w[31:24]; b = w[23:16]; d = w[15:8]; e = w[7:0];
    u = xtime(xtime(a ^ d));
    v = xtime(xtime(b ^ e));
    inv_mix_col = mix_col({a ^ u, b ^ v, d ^ u, e ^ v});
  endfunction

endpackage

FILE: hw/rtl/acbc_ctrl.sv
module acbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tlast,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  acbc_pkg::acbc_sts_t sts,
  output acbc_pkg::acbc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] kidx_r, kidx_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic       keys_ready_r, keys_ready_nxt;
  logic       at_start_r, at_start_nxt;
  logic       use_iv_r, use_iv_nxt;
  logic       pad_pass_r, pad_pass_nxt;
  logic [5:0] key_last;

  assign key_last = 6'({sts.nr, 2'b00} + 6'd3);

  always_comb begin
    state_nxt      = state_r;
    kidx_nxt       = kidx_r;
    rnd_nxt        = rnd_r;
    keys_ready_nxt = keys_ready_r;
    at_start_nxt   = at_start_r;
    use_iv_nxt     = use_iv_r;
    pad_pass_nxt   = pad_pass_r;
    cmd            = '0;
    in_tready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture  = 1'b1;
          use_iv_nxt   = at_start_r;
          at_start_nxt = in_tlast;
          pad_pass_nxt = 1'b0;
          kidx_nxt     = '0;
          state_nxt    = keys_ready_r ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.kexp = 1'b1;
        cmd.kidx = kidx_r;
        if (kidx_r == key_last) begin
          keys_ready_nxt = 1'b1;
          state_nxt      = ST_LOAD;
        end else begin
          kidx_nxt = kidx_r + 6'd1;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        cmd.use_iv = use_iv_r && !pad_pass_r;
        cmd.pad    = pad_pass_r;
        cmd.rk_idx = sts.dir ? sts.nr : 4'd0;
        rnd_nxt    = 4'd1;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round       = 1'b1;
        cmd.final_round = (rnd_r == sts.nr);
        cmd.rk_idx      = sts.dir ? (sts.nr - rnd_r) : rnd_r;
        if (rnd_r == sts.nr) begin
          state_nxt = ST_FIN;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          if (sts.extra && !pad_pass_r) begin
            pad_pass_nxt = 1'b1;
            state_nxt    = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && (cfg_addr == acbc_pkg::REG_KEY_SIZE || cfg_addr == acbc_pkg::REG_KEY_WORD0 ||
        cfg_addr == acbc_pkg::REG_KEY_WORD1 || cfg_addr == acbc_pkg::REG_KEY_WORD2 ||
        cfg_addr == acbc_pkg::REG_KEY_WORD3)) begin
      keys_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      kidx_r       <= '0;
      rnd_r        <= '0;
      keys_ready_r <= 1'b0;
      at_start_r   <= 1'b1;
      use_iv_r     <= 1'b0;
      pad_pass_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kidx_r       <= kidx_nxt;
      rnd_r        <= rnd_nxt;
      keys_ready_r <= keys_ready_nxt;
      at_start_r   <= at_start_nxt;
      use_iv_r     <= use_iv_nxt;
      pad_pass_r   <= pad_pass_nxt;
    end
  end

endmodule

FILE: hw/rtl/acbc_dp.sv
module acbc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [135:0]        in_tdata,
  input  logic                in_tlast,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [63:0]         cfg_wdata,
  input  acbc_pkg::acbc_cmd_t cmd,
  output acbc_pkg::acbc_sts_t sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [135:0]        out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  logic         dir_r;
  logic [1:0]   ks_r;
  logic [255:0] key_r;
  logic [127:0] iv_r;

  logic [127:0] rk_mem [15];
  logic [31:0]  win_r [8];
  logic [2:0]   kmod_r;
  logic [7:0]   rc_r;

  logic [127:0] blk_r, cv_r, s_r;
  logic         op_dir_r, last_r, extra_r, pad_r;

  logic         out_valid_r;
  logic [127:0] out_blk_r;
  logic [4:0]   out_vb_r;
  logic         out_fin_r, out_err_r;

  logic [3:0]   nr, nk;
  logic [127:0] rk;

  assign nr = (ks_r == acbc_pkg::KS_128) ? 4'd10 : (ks_r == acbc_pkg::KS_192) ? 4'd12 : 4'd14;
  assign nk = nr - 4'd6;
  assign rk = rk_mem[cmd.rk_idx];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      ks_r  <= '0;
      key_r <= '0;
      iv_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        acbc_pkg::REG_DIRECTION: dir_r          <= cfg_wdata[0];
        acbc_pkg::REG_KEY_SIZE:  ks_r           <= cfg_wdata[1:0];
        acbc_pkg::REG_KEY_WORD0: key_r[255:192] <= cfg_wdata;
        acbc_pkg::REG_KEY_WORD1: key_r[191:128] <= cfg_wdata;
        acbc_pkg::REG_KEY_WORD2: key_r[127:64]  <= cfg_wdata;
        acbc_pkg::REG_KEY_WORD3: key_r[63:0]    <= cfg_wdata;
        acbc_pkg::REG_IV_HIGH:   iv_r[127:64]   <= cfg_wdata;
        acbc_pkg::REG_IV_LOW:    iv_r[63:0]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // key expansion, one word per cycle
  logic [2:0]  kmod_cur, kmod_nxt;
  logic [7:0]  rc_cur, rc_nxt;
  logic [31:0] kw_t, kw_new, kw_rot;
  logic [5:0]  kidx_nk;

  always_comb begin
    kmod_cur = (cmd.kidx == 6'd0) ? 3'd0 : kmod_r;
    rc_cur   = (cmd.kidx == 6'd0) ? 8'h01 : rc_r;
    kmod_nxt = (kmod_cur == 3'(nk - 4'd1)) ? 3'd0 : kmod_cur + 3'd1;
    rc_nxt   = rc_cur;
    kidx_nk  = {2'b00, nk};
    kw_t     = win_r[7];
    kw_rot   = {kw_t[23:0], kw_t[31:24]};
    if (cmd.kidx < kidx_nk) begin
      kw_new = key_r[255 - 32 * cmd.kidx[2:0] -: 32];
    end else begin
      if (kmod_cur == 3'd0) begin
        kw_t = {acbc_pkg::SBOX[kw_rot[31:24]], acbc_pkg::SBOX[kw_rot[23:16]],
                acbc_pkg::SBOX[kw_rot[15:8]], acbc_pkg::SBOX[kw_rot[7:0]]} ^ {rc_cur, 24'h0};
        rc_nxt = acbc_pkg::xtime(rc_cur);
      end else if (nk == 4'd8 && kmod_cur == 3'd4) begin
        kw_t = {acbc_pkg::SBOX[kw_t[31:24]], acbc_pkg::SBOX[kw_t[23:16]],
                acbc_pkg::SBOX[kw_t[15:8]], acbc_pkg::SBOX[kw_t[7:0]]};
      end
      kw_new = win_r[3'(4'd8 - nk)] ^ kw_t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kexp) begin
      rk_mem[cmd.kidx[5:2]][127 - 32 * cmd.kidx[1:0] -: 32] <= kw_new;
      for (int i = 0; i < 7; i++) win_r[i] <= win_r[i + 1];
      win_r[7] <= kw_new;
      kmod_r   <= kmod_nxt;
      rc_r     <= rc_nxt;
    end
  end

  // input capture with pkcs7 fill on encryption
  logic [4:0]   nb;
  logic [127:0] blk_in;

  always_comb begin
    nb     = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];
    blk_in = {in_tdata[63:0], in_tdata[127:64]};
    if (!dir_r && in_tlast && nb < 5'd16) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= nb) blk_in[127 - 8 * i -: 8] = 8'(5'd16 - nb);
      end
    end
  end

  // round function
  logic [127:0] cv_src, blk_src, sub_s, shf_s, mix_s, enc_s, dec_a, dec_b, dec_s;

  always_comb begin
    cv_src  = cmd.use_iv ? iv_r : cv_r;
    blk_src = cmd.pad ? {16{8'h10}} : blk_r;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf_s[127 - 8 * (r + 4 * c) -: 8] =
          acbc_pkg::SBOX[s_r[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
        dec_a[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] =
          acbc_pkg::INV_SBOX[s_r[127 - 8 * (r + 4 * c) -: 8]];
      end
    end
    sub_s = shf_s;
    for (int c = 0; c < 4; c++) begin
      mix_s[127 - 32 * c -: 32] = acbc_pkg::mix_col(sub_s[127 - 32 * c -: 32]);
    end
    enc_s = (cmd.final_round ? sub_s : mix_s) ^ rk;
    dec_b = dec_a ^ rk;
    for (int c = 0; c < 4; c++) begin
      dec_s[127 - 32 * c -: 32] = acbc_pkg::inv_mix_col(dec_b[127 - 32 * c -: 32]);
    end
    if (cmd.final_round) dec_s = dec_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk_r    <= blk_in;
      op_dir_r <= dir_r;
      last_r   <= in_tlast;
      extra_r  <= !dir_r && in_tlast && (nb == 5'd16);
    end
    if (cmd.load) begin
      pad_r <= cmd.pad;
      if (cmd.use_iv) cv_r <= iv_r;
      s_r <= op_dir_r ? (blk_r ^ rk) : (blk_src ^ cv_src ^ rk);
    end else if (cmd.round) begin
      s_r <= op_dir_r ? dec_s : enc_s;
    end
    if (cmd.finish) cv_r <= op_dir_r ? blk_r : s_r;
  end

  // result and padding check
  logic [127:0] res;
  logic [7:0]   pb;
  logic         pad_ok;

  always_comb begin
    res    = op_dir_r ? (s_r ^ cv_r) : s_r;
    pb     = res[7:0];
    pad_ok = (pb >= 8'd1) && (pb <= 8'd16);
    for (int i = 0; i < 16; i++) begin
      if (8'(i) < pb && res[8 * i +: 8] != pb) pad_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_blk_r <= res;
      out_vb_r  <= (op_dir_r && last_r && pad_ok) ? 5'(5'd16 - pb[4:0]) : 5'd16;
      out_fin_r <= op_dir_r ? last_r : (pad_r || (last_r && !extra_r));
      out_err_r <= op_dir_r && last_r && !pad_ok;
    end
  end

  assign sts.nr       = nr;
  assign sts.dir      = op_dir_r;
  assign sts.extra    = extra_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_vb_r, out_blk_r[63:0], out_blk_r[127:64]};
  assign out_tlast  = out_fin_r;
  assign out_tuser  = out_err_r;

endmodule

FILE: hw/rtl/aes_cbc_block_cipher_with_padding_unit.sv
// a result is valid after the load step, the Nr rounds and the finish step, Nr set by key size
// the round unit runs one round per cycle; the next block is taken only after the last one has finished
// after a key change the first block first expands 4 * (Nr + 1) key words
// a full last block on encryption adds a second pass that encrypts a block of padding
// a stalled result holds the next block after its final round until the output register frees
// rst_n is synchronous, active low; control and configuration registers clear, chaining restarts from the iv
module aes_cbc_block_cipher_with_padding_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_high, block_low, message_bytes
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // result_high, result_low, valid_bytes
  output logic         out_tlast,
  output logic         out_tuser,  // pad_error
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  acbc_pkg::acbc_cmd_t cmd;
  acbc_pkg::acbc_sts_t sts;

  acbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .sts       (sts),
    .cmd       (cmd)
  );

  acbc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: test/aes_cbc_checker.sv
`timescale 1ns / 1ps
module aes_cbc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         out_tlast,
  input  logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [127:0] blk;
    logic [4:0]   nvalid;
    logic         fin;
    logic         err;
  } cipher_out_t;

  cipher_out_t  expected_blocks[$];
  logic         dir_q;
  logic [1:0]   ksize_q;
  logic [63:0]  key_q [4];
  logic [127:0] iv_q;
  logic [127:0] chain_q;
  logic         msg_start;
  logic         keys_valid;
  logic [31:0]  rkeys [60];
  int           nrounds;

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gmul2(a);
    end
    return p;
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  task automatic build_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = (ksize_q == 0) ? 4 : (ksize_q == 1) ? 6 : 8;
    nrounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rkeys[i] = i[0] ? key_q[i / 2][31:0] : key_q[i / 2][63:32];
    for (int i = nk; i < 4 * (nrounds + 1); i++) begin
      t = rkeys[i - 1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {acbc_pkg::SBOX[t[31:24]], acbc_pkg::SBOX[t[23:16]],
             acbc_pkg::SBOX[t[15:8]], acbc_pkg::SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = gmul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {acbc_pkg::SBOX[t[31:24]], acbc_pkg::SBOX[t[23:16]],
             acbc_pkg::SBOX[t[15:8]], acbc_pkg::SBOX[t[7:0]]};
      end
      rkeys[i] = rkeys[i - nk] ^ t;
    end
    keys_valid = 1;
  endtask

  function automatic logic [127:0] round_key(input int r);
    return {rkeys[4 * r], rkeys[4 * r + 1], rkeys[4 * r + 2], rkeys[4 * r + 3]};
  endfunction

  function automatic logic [127:0] shift(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = byte_at(s, r + 4 * c);
        else t[127 - 8 * (r + 4 * c) -: 8] = byte_at(s, r + 4 * ((c + r) % 4));
    return t;
  endfunction

  function automatic logic [127:0] cipher_fwd(input logic [127:0] s);
    logic [7:0] a, b, d, e;
    s ^= round_key(0);
    for (int rn = 1; rn <= nrounds; rn++) begin
      for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = acbc_pkg::SBOX[byte_at(s, i)];
      s = shift(s, 0);
      if (rn != nrounds)
        for (int c = 0; c < 4; c++) begin
          a = byte_at(s, 4 * c); b = byte_at(s, 4 * c + 1);
          d = byte_at(s, 4 * c + 2); e = byte_at(s, 4 * c + 3);
          s[127 - 32 * c -: 32] = {gmul2(a) ^ gmul2(b) ^ b ^ d ^ e,
                                   a ^ gmul2(b) ^ gmul2(d) ^ d ^ e,
                                   a ^ b ^ gmul2(d) ^ gmul2(e) ^ e,
                                   gmul2(a) ^ a ^ b ^ d ^ gmul2(e)};
        end
      s ^= round_key(rn);
    end
    return s;
  endfunction

  function automatic logic [127:0] cipher_inv(input logic [127:0] s);
    logic [7:0] a, b, d, e;
    s ^= round_key(nrounds);
    for (int rn = nrounds - 1; rn >= 0; rn--) begin
      s = shift(s, 1);
      for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = acbc_pkg::INV_SBOX[byte_at(s, i)];
      s ^= round_key(rn);
      if (rn != 0)
        for (int c = 0; c < 4; c++) begin
          a = byte_at(s, 4 * c); b = byte_at(s, 4 * c + 1);
          d = byte_at(s, 4 * c + 2); e = byte_at(s, 4 * c + 3);
          s[127 - 32 * c -: 32] = {
            gmul(a, 14) ^ gmul(b, 11) ^ gmul(d, 13) ^ gmul(e, 9),
            gmul(a, 9) ^ gmul(b, 14) ^ gmul(d, 11) ^ gmul(e, 13),
            gmul(a, 13) ^ gmul(b, 9) ^ gmul(d, 14) ^ gmul(e, 11),
            gmul(a, 11) ^ gmul(b, 13) ^ gmul(d, 9) ^ gmul(e, 14)};
        end
    end
    return s;
  endfunction

  task automatic predict_blocks(input logic [127:0] din, input logic [4:0] mbytes,
                                input logic last);
    logic [127:0] b;
    int nb, p;
    bit ok;
    cipher_out_t o;
    if (!keys_valid) build_schedule();
    if (msg_start) chain_q = iv_q;
    msg_start = last;
    b = din;
    if (!dir_q) begin
      nb = (mbytes > 16) ? 16 : mbytes;
      if (last && nb < 16) begin
        for (int i = nb; i < 16; i++) b[127 - 8 * i -: 8] = 8'(16 - nb);
        chain_q = cipher_fwd(b ^ chain_q);
        o = '{chain_q, 5'd16, 1'b1, 1'b0};
        expected_blocks = {expected_blocks, o};
      end else begin
        chain_q = cipher_fwd(b ^ chain_q);
        o = '{chain_q, 5'd16, 1'b0, 1'b0};
        expected_blocks = {expected_blocks, o};
        if (last) begin
          chain_q = cipher_fwd({16{8'h10}} ^ chain_q);
          o = '{chain_q, 5'd16, 1'b1, 1'b0};
          expected_blocks = {expected_blocks, o};
        end
      end
    end else begin
      b = cipher_inv(din) ^ chain_q;
      chain_q = din;
      o = '{b, 5'd16, last, 1'b0};
      if (last) begin
        p = byte_at(b, 15);
        ok = (p >= 1 && p <= 16);
        for (int i = 0; ok && i < p; i++)
          if (byte_at(b, 15 - i) != p) ok = 0;
        if (ok) o.nvalid = 5'(16 - p);
        else o.err = 1;
      end
      expected_blocks = {expected_blocks, o};
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cipher_out_t want;
    logic [127:0] got;
    if (!rst_n) begin
      dir_q = 0;
      ksize_q = 0;
      key_q = '{default: '0};
      iv_q = '0;
      chain_q = '0;
      msg_start = 1;
      keys_valid = 0;
      fail_count = 0;
      expected_blocks.delete();
    end else begin
      if (cfg_we)
        case (cfg_addr)
          acbc_pkg::REG_DIRECTION: dir_q = cfg_wdata[0];
          acbc_pkg::REG_KEY_SIZE: begin ksize_q = cfg_wdata[1:0]; keys_valid = 0; end
          acbc_pkg::REG_KEY_WORD0: begin key_q[0] = cfg_wdata; keys_valid = 0; end
          acbc_pkg::REG_KEY_WORD1: begin key_q[1] = cfg_wdata; keys_valid = 0; end
          acbc_pkg::REG_KEY_WORD2: begin key_q[2] = cfg_wdata; keys_valid = 0; end
          acbc_pkg::REG_KEY_WORD3: begin key_q[3] = cfg_wdata; keys_valid = 0; end
          acbc_pkg::REG_IV_HIGH: iv_q[127:64] = cfg_wdata;
          acbc_pkg::REG_IV_LOW: iv_q[63:0] = cfg_wdata;
          default: ;
        endcase
      if (in_tvalid && in_tready)
        predict_blocks({in_tdata[63:0], in_tdata[127:64]}, in_tdata[132:128], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_blocks.pop_front();
          got = {out_tdata[63:0], out_tdata[127:64]};
          if (got !== want.blk)
            report_mismatch($sformatf("block %h, expected %h", got, want.blk));
          if (out_tdata[132:128] !== want.nvalid)
            report_mismatch($sformatf("valid_bytes %0d, expected %0d",
                                      out_tdata[132:128], want.nvalid));
          if (out_tlast !== want.fin)
            report_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.fin));
          if (out_tuser !== want.err)
            report_mismatch($sformatf("pad_error %b, expected %b", out_tuser, want.err));
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

FILE: test/tb_aes_cbc_block_cipher_with_padding_unit.sv
`timescale 1ns / 1ps
module tb_aes_cbc_block_cipher_with_padding_unit;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [135:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [63:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           blocks_sent;
  int           messages_sent;
  bit           sink_quiet;

  localparam int WATCHDOG_LIMIT = 4000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  aes_cbc_block_cipher_with_padding_unit dut (.*);

  aes_cbc_checker checker_i (.*);

  // receiver stalls at random before each result unless sink_quiet
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL aes_cbc_block_cipher_with_padding_unit");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_idle();
    repeat (60) @(posedge clk);
  endtask

  task automatic send_block(input logic [127:0] blk, input logic [4:0] mb, input logic last,
                            input bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, mb, blk};
    in_tlast <= last;
    @(posedge clk iff in_tready);
    blocks_sent++;
    if (last) messages_sent++;
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic setup(input logic dir, input logic [1:0] ks, input bit extreme);
    write_reg(acbc_pkg::REG_DIRECTION, 64'(dir));
    write_reg(acbc_pkg::REG_KEY_SIZE, 64'(ks));
    for (int i = 0; i < 4; i++)
      write_reg(acbc_pkg::REG_KEY_WORD0 + 3'(i),
                extreme ? {64{ks[0]}} : {$urandom, $urandom});
    write_reg(acbc_pkg::REG_IV_HIGH, extreme ? {64{dir}} : {$urandom, $urandom});
    write_reg(acbc_pkg::REG_IV_LOW, extreme ? {64{~dir}} : {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // message of random blocks, last one with a random byte count
  task automatic send_message(input int nblk, input bit nogap);
    logic [4:0] mb;
    for (int i = 0; i < nblk; i++) begin
      mb = (i == nblk - 1) ? 5'($urandom_range(0, 20)) : 5'($urandom_range(0, 31));
      send_block(rand_block(), mb, i == nblk - 1, nogap);
    end
  endtask

  initial begin
    int ks, nblk;
    logic [127:0] ct;
    blocks_sent = 0;
    messages_sent = 0;
    sink_quiet = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset keys, extreme blocks, every padding length class
    send_block('0, 5'd0, 1'b1, 1'b0);
    send_block('1, 5'd16, 1'b1, 1'b0);
    send_block('1, 5'd31, 1'b0, 1'b0);
    send_block('0, 5'd17, 1'b1, 1'b0);
    send_block(rand_block(), 5'd15, 1'b1, 1'b0);
    send_block(rand_block(), 5'd1, 1'b1, 1'b0);
    drain();
    setup(1'b0, 2'd3, 1'b1);
    send_block('1, 5'd5, 1'b1, 1'b0);
    drain();
    setup(1'b1, 2'd2, 1'b1);
    send_block('0, 5'd0, 1'b1, 1'b0);
    send_block('1, 5'd0, 1'b0, 1'b0);
    send_block(rand_block(), 5'd0, 1'b1, 1'b0);
    drain();
    setup(1'b1, 2'd1, 1'b0);
    send_block(rand_block(), 5'd16, 1'b1, 1'b1);
    drain();
    // direction change in mid-message
    send_block(rand_block(), 5'd16, 1'b0, 1'b0);
    drain();
    write_reg(acbc_pkg::REG_DIRECTION, 64'd0);
    cfg_we <= 1'b0;
    send_block(rand_block(), 5'd9, 1'b1, 1'b0);
    drain();

    // random phases, one configuration and a handful of messages each
    while (blocks_sent < 420) begin
      ks = $urandom_range(0, 3);
      setup(1'($urandom_range(0, 1)), 2'(ks), $urandom_range(0, 7) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        nblk = $urandom_range(1, 4);
        send_message(nblk, sink_quiet);
        if ($urandom_range(0, 5) == 0) begin
          // hold off until all results are back
          wait_idle();
        end
      end
      drain();
    end

    // encrypt, then decrypt the ciphertext; padding valid for p < 16
    setup(1'b0, 2'd0, 1'b0);
    write_reg(acbc_pkg::REG_KEY_WORD0, 64'h0123456789abcdef);
    cfg_we <= 1'b0;
    for (int p = 0; p <= 16; p += 4) begin
      send_block(rand_block(), 5'(p), 1'b1, 1'b0);
      drain();
      ct = out_tdata[127:0];
      write_reg(acbc_pkg::REG_DIRECTION, 64'd1);
      cfg_we <= 1'b0;
      send_block(ct, 5'd0, 1'b1, 1'b0);
      drain();
      write_reg(acbc_pkg::REG_DIRECTION, 64'd0);
      cfg_we <= 1'b0;
    end

    drain();
    $display("covered %0d blocks in %0d messages over all key sizes and both directions",
             blocks_sent, messages_sent);
    if (fail_count == 0) begin
      $display("PASS aes_cbc_block_cipher_with_padding_unit");
    end else begin
      $display("FAIL aes_cbc_block_cipher_with_padding_unit");
    end
    $finish;
  end

endmodule
